// ===== hw/rtl/temperature_pid_fan_duty_defines.svh =====
// Assertion macros shared by the fan duty PID controller RTL.
`ifndef TEMPERATURE_PID_FAN_DUTY_DEFINES_SVH
`define TEMPERATURE_PID_FAN_DUTY_DEFINES_SVH

// Same-cycle check: whenever cond holds, conseq must hold too.
`define TPFD_ASSERT_HOLDS(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
    else $error(msg);

// Next-cycle check: whenever cond holds, conseq must hold in the next cycle.
`define TPFD_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
    else $error(msg);

`endif

// ===== hw/rtl/tpfd_pkg.sv =====
// Package with widths, register codes and shared types of the fan duty PID controller.
package tpfd_pkg;

  // Sample and fixed-point formats.
  localparam int ADC_BITS    = 12;
  localparam int SUM_BITS    = 40;
  localparam int TEMP_BITS   = 19;
  localparam int TEMP_SCALE  = 512000;
  localparam int SP_BITS     = 9;
  localparam int SP_FRAC     = 10;
  localparam int ERR_BITS    = 21;
  localparam int DIFF_BITS   = ERR_BITS + 1;
  localparam int GAIN_BITS   = 24;
  localparam int OFS_BITS    = 12;
  localparam int DUTY_BITS   = 16;
  localparam int CMD_BITS    = 24;
  localparam int FRAC_BITS   = 26;
  localparam int CTRL_BITS   = 64;
  localparam int Q_BITS      = CTRL_BITS - FRAC_BITS;
  localparam int LIMIT_SHIFT = 60;

  // Integral product split into two narrower multiplies.
  localparam int SUM_LO_BITS = SUM_BITS / 2;
  localparam int SUM_HI_BITS = SUM_BITS - SUM_LO_BITS;
  localparam int PE_BITS     = GAIN_BITS + 1 + ERR_BITS;
  localparam int PD_BITS     = GAIN_BITS + 1 + DIFF_BITS;
  localparam int PL_BITS     = GAIN_BITS + SUM_LO_BITS;
  localparam int PH_BITS     = GAIN_BITS + 1 + SUM_HI_BITS;
  localparam int PI_BITS     = GAIN_BITS + 1 + SUM_BITS;
  localparam int PI_CMP_BITS = (PI_BITS > LIMIT_SHIFT + 2) ? PI_BITS : LIMIT_SHIFT + 2;

  localparam logic signed [PI_CMP_BITS-1:0] PI_POS_LIMIT = PI_CMP_BITS'(64'd1 << LIMIT_SHIFT);
  localparam logic signed [PI_CMP_BITS-1:0] PI_NEG_LIMIT = -PI_POS_LIMIT;
  localparam logic signed [CMD_BITS-1:0] CMD_MAX = {1'b0, {(CMD_BITS-1){1'b1}}};
  localparam logic signed [CMD_BITS-1:0] CMD_MIN = {1'b1, {(CMD_BITS-1){1'b0}}};

  // Pipeline registers ahead of the output register.
  localparam int PIPE_STAGES = 6;

  // Configuration port.
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 24;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_SETPOINT_DEG = 3'd0,
    CFG_KP_GAIN      = 3'd1,
    CFG_KI_GAIN      = 3'd2,
    CFG_KD_GAIN      = 3'd3,
    CFG_DUTY_OFFSET  = 3'd4,
    CFG_DUTY_UPPER   = 3'd5
  } cfg_reg_t;

  localparam logic [SP_BITS-1:0]   SETPOINT_RST = 9'd25;
  localparam logic [GAIN_BITS-1:0] KP_RST       = 24'd32768;
  localparam logic [GAIN_BITS-1:0] KI_RST       = 24'd655;
  localparam logic [GAIN_BITS-1:0] KD_RST       = 24'd32768;
  localparam logic [OFS_BITS-1:0]  OFFSET_RST   = 12'd400;
  localparam logic [DUTY_BITS-1:0] UPPER_RST    = 16'd4000;

  // Error terms of one sample, handed from the error stage to the multipliers.
  typedef struct packed {
    logic signed [ERR_BITS-1:0]  err;
    logic signed [DIFF_BITS-1:0] diff;
    logic signed [SUM_BITS-1:0]  sum;
  } err_t;

  // One finished result.
  typedef struct packed {
    logic signed [CMD_BITS-1:0] drive_command;
    logic [DUTY_BITS-1:0]       duty_value;
    logic                       duty_written;
  } res_t;

endpackage

// ===== hw/rtl/tpfd_in_if.sv =====
// Sample channel interface of the fan duty PID controller.
interface tpfd_in_if import tpfd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ADC_BITS-1:0] adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink (input valid, input adc_sample, output ready);
endinterface

// ===== hw/rtl/tpfd_out_if.sv =====
// Result channel interface of the fan duty PID controller.
interface tpfd_out_if import tpfd_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [CMD_BITS-1:0] drive_command;
  logic [DUTY_BITS-1:0]       duty_value;
  logic                       duty_written;

  modport source (output valid, output drive_command, output duty_value,
                  output duty_written, input ready);
  modport sink (input valid, input drive_command, input duty_value,
                input duty_written, output ready);
endinterface

// ===== hw/rtl/tpfd_error.sv =====
// Error, difference and saturating integral of one sample, with the PID history.
`include "temperature_pid_fan_duty_defines.svh"

module tpfd_error import tpfd_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [ADC_BITS-1:0] sample,
  input  logic [SP_BITS-1:0]  setpoint_deg,
  output err_t                terms
);

  logic signed [ERR_BITS-1:0] last_error_r;
  logic signed [SUM_BITS-1:0] error_sum_r;

  logic [ADC_BITS+TEMP_BITS-1:0] temp_prod;
  logic [TEMP_BITS-1:0]          temp_q10;
  logic [TEMP_BITS-1:0]          sp_q10;
  logic signed [TEMP_BITS:0]     err_raw;
  logic signed [SUM_BITS:0]      sum_wide;
  logic signed [SUM_BITS-1:0]    error_sum_nxt;

  always_comb begin
    temp_prod = (ADC_BITS+TEMP_BITS)'(sample) * (ADC_BITS+TEMP_BITS)'(TEMP_SCALE);
    temp_q10  = temp_prod[ADC_BITS+TEMP_BITS-1:ADC_BITS];
    sp_q10    = {setpoint_deg, {SP_FRAC{1'b0}}};
    // Both operands stay below 2^19, so the error never reaches the 21-bit limits.
    err_raw   = $signed({1'b0, sp_q10}) - $signed({1'b0, temp_q10});

    sum_wide = (SUM_BITS+1)'(error_sum_r) + (SUM_BITS+1)'(last_error_r);
    if (sum_wide[SUM_BITS] != sum_wide[SUM_BITS-1]) begin
      error_sum_nxt = sum_wide[SUM_BITS] ? {1'b1, {(SUM_BITS-1){1'b0}}}
                                         : {1'b0, {(SUM_BITS-1){1'b1}}};
    end else begin
      error_sum_nxt = sum_wide[SUM_BITS-1:0];
    end

    terms.err  = ERR_BITS'(err_raw);
    terms.diff = DIFF_BITS'(terms.err) - DIFF_BITS'(last_error_r);
    terms.sum  = error_sum_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_error_r <= '0;
      error_sum_r  <= '0;
    end else if (step) begin
      last_error_r <= terms.err;
      error_sum_r  <= error_sum_nxt;
    end
  end

  `TPFD_ASSERT_NEXT(a_sum_never_drops, step && !last_error_r[ERR_BITS-1],
                    error_sum_r >= $past(error_sum_r),
                    "integral fell after adding a non-negative error")

endmodule

// ===== hw/rtl/tpfd_duty.sv =====
// Duty update or hold decision, duty register and result register.
`include "temperature_pid_fan_duty_defines.svh"

module tpfd_duty import tpfd_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       load,
  input  logic signed [CMD_BITS-1:0] cmd,
  input  logic [OFS_BITS-1:0]        duty_offset,
  input  logic [DUTY_BITS-1:0]       duty_upper,
  output res_t                       res
);

  logic signed [CMD_BITS-1:0] cmd_r;
  logic [DUTY_BITS-1:0]       held_duty_r;
  logic                       written_r;

  logic signed [CMD_BITS-1:0] ofs_s;
  logic signed [CMD_BITS-1:0] upper_s;
  logic [DUTY_BITS-1:0]       held_duty_nxt;
  logic                       written_nxt;

  always_comb begin
    ofs_s   = $signed({{(CMD_BITS-OFS_BITS){1'b0}}, duty_offset});
    upper_s = $signed({{(CMD_BITS-DUTY_BITS){1'b0}}, duty_upper});
    held_duty_nxt = held_duty_r;
    written_nxt   = 1'b0;
    if (cmd > ofs_s && cmd < upper_s) begin
      held_duty_nxt = cmd[DUTY_BITS-1:0];
      written_nxt   = 1'b1;
    end else if (cmd < ofs_s) begin
      held_duty_nxt = '0;
      written_nxt   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_duty_r <= '0;
      written_r   <= 1'b0;
    end else if (load) begin
      held_duty_r <= held_duty_nxt;
      written_r   <= written_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cmd_r <= cmd;
    end
  end

  assign res.drive_command = cmd_r;
  assign res.duty_value    = held_duty_r;
  assign res.duty_written  = written_r;

  `TPFD_ASSERT_HOLDS(a_duty_from_command, written_r && (held_duty_r != '0), (held_duty_r == cmd_r[DUTY_BITS-1:0]) && !cmd_r[CMD_BITS-1], "rewritten duty does not match the drive command")

endmodule

// ===== hw/rtl/temperature_pid_fan_duty.sv =====
// Top level of the temperature PID controller that sets a fan PWM duty.
// Throughput is one sample per clock while the output is taken; the seven-register
// pipeline has no feedback loop except the integral and last-error update in the
// error stage. A result stays at the output until taken.
// Reset (synchronous, rst_n low) empties the pipeline, clears the PID state and duty,
// and loads the default configuration.
`include "temperature_pid_fan_duty_defines.svh"

module temperature_pid_fan_duty import tpfd_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
  tpfd_in_if.sink                  in_ch,
  tpfd_out_if.source               out_ch
);

  // Configuration registers. Writes to unused indexes are dropped.
  logic [SP_BITS-1:0]   setpoint_deg_r;
  logic [GAIN_BITS-1:0] kp_gain_r;
  logic [GAIN_BITS-1:0] ki_gain_r;
  logic [GAIN_BITS-1:0] kd_gain_r;
  logic [OFS_BITS-1:0]  duty_offset_r;
  logic [DUTY_BITS-1:0] duty_upper_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setpoint_deg_r <= SETPOINT_RST;
      kp_gain_r      <= KP_RST;
      ki_gain_r      <= KI_RST;
      kd_gain_r      <= KD_RST;
      duty_offset_r  <= OFFSET_RST;
      duty_upper_r   <= UPPER_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_SETPOINT_DEG: setpoint_deg_r <= cfg_wdata[SP_BITS-1:0];
        CFG_KP_GAIN:      kp_gain_r      <= cfg_wdata[GAIN_BITS-1:0];
        CFG_KI_GAIN:      ki_gain_r      <= cfg_wdata[GAIN_BITS-1:0];
        CFG_KD_GAIN:      kd_gain_r      <= cfg_wdata[GAIN_BITS-1:0];
        CFG_DUTY_OFFSET:  duty_offset_r  <= cfg_wdata[OFS_BITS-1:0];
        CFG_DUTY_UPPER:   duty_upper_r   <= cfg_wdata[DUTY_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline flow control. Each stage takes a new item when it is empty or when the
  // stage behind it takes its current one, so a stalled output only blocks the
  // input once every stage is occupied.
  logic [PIPE_STAGES-1:0] stg_v_r;
  logic                   out_valid_r;
  logic [PIPE_STAGES:0]   rdy;
  logic [PIPE_STAGES:0]   ld;

  always_comb begin
    rdy[PIPE_STAGES] = !out_valid_r || out_ch.ready;
    for (int k = PIPE_STAGES - 1; k >= 0; k--) begin
      rdy[k] = !stg_v_r[k] || rdy[k+1];
    end
    ld[0] = rdy[0] && in_ch.valid;
    for (int k = 1; k <= PIPE_STAGES; k++) begin
      ld[k] = rdy[k] && stg_v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy[0]) begin
        stg_v_r[0] <= in_ch.valid;
      end
      for (int k = 1; k < PIPE_STAGES; k++) begin
        if (rdy[k]) begin
          stg_v_r[k] <= stg_v_r[k-1];
        end
      end
      if (rdy[PIPE_STAGES]) begin
        out_valid_r <= stg_v_r[PIPE_STAGES-1];
      end
    end
  end

  assign in_ch.ready  = rdy[0];
  assign out_ch.valid = out_valid_r;

  // Stage 0: input register.
  logic [ADC_BITS-1:0] sample_r;

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      sample_r <= in_ch.adc_sample;
    end
  end

  // Stage 1: error against the setpoint, derivative and integral. The PID history
  // advances exactly when a sample moves into this stage.
  err_t terms_nxt;
  err_t terms_r;

  tpfd_error u_error (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (ld[1]),
    .sample       (sample_r),
    .setpoint_deg (setpoint_deg_r),
    .terms        (terms_nxt)
  );

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      terms_r <= terms_nxt;
    end
  end

  // Stage 2: gain multiplies. The wide integral is split into a signed upper half
  // and an unsigned lower half so that each multiplier stays narrow.
  logic signed [PE_BITS-1:0]     pe_nxt, pe_r;
  logic signed [PD_BITS-1:0]     pd_nxt, pd_r;
  logic [PL_BITS-1:0]            pl_nxt, pl_r;
  logic signed [PH_BITS-1:0]     ph_nxt, ph_r;
  logic [SUM_LO_BITS-1:0]        sum_lo;
  logic signed [SUM_HI_BITS-1:0] sum_hi;

  always_comb begin
    sum_lo = terms_r.sum[SUM_LO_BITS-1:0];
    sum_hi = $signed(terms_r.sum[SUM_BITS-1:SUM_LO_BITS]);
    pe_nxt = PE_BITS'($signed({1'b0, kp_gain_r})) * PE_BITS'(terms_r.err);
    pd_nxt = PD_BITS'($signed({1'b0, kd_gain_r})) * PD_BITS'(terms_r.diff);
    pl_nxt = PL_BITS'(ki_gain_r) * PL_BITS'(sum_lo);
    ph_nxt = PH_BITS'($signed({1'b0, ki_gain_r})) * PH_BITS'(sum_hi);
  end

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      pe_r <= pe_nxt;
      pd_r <= pd_nxt;
      pl_r <= pl_nxt;
      ph_r <= ph_nxt;
    end
  end

  // Stage 3: rebuild the integral product and clamp it to +-2^60; fold the offset,
  // proportional and derivative terms into one base value.
  logic signed [PI_BITS-1:0]     pi_full;
  logic signed [PI_CMP_BITS-1:0] pi_ext;
  logic signed [PI_CMP_BITS-1:0] pi_clamp;
  logic signed [CTRL_BITS-1:0]   pi_nxt, pi_r;
  logic signed [CTRL_BITS-1:0]   base_nxt, base_r;

  always_comb begin
    pi_full = $signed({ph_r, {SUM_LO_BITS{1'b0}}})
            + $signed({{(SUM_HI_BITS+1){1'b0}}, pl_r});
    pi_ext  = PI_CMP_BITS'(pi_full);
    if (pi_ext > PI_POS_LIMIT) begin
      pi_clamp = PI_POS_LIMIT;
    end else if (pi_ext < PI_NEG_LIMIT) begin
      pi_clamp = PI_NEG_LIMIT;
    end else begin
      pi_clamp = pi_ext;
    end
    pi_nxt   = CTRL_BITS'(pi_clamp);
    base_nxt = CTRL_BITS'($signed({1'b0, duty_offset_r, {FRAC_BITS{1'b0}}}))
             - CTRL_BITS'(pe_r) - CTRL_BITS'(pd_r);
  end

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      pi_r   <= pi_nxt;
      base_r <= base_nxt;
    end
  end

  // Stage 4: offset minus the full control value, still in Q26.
  logic signed [CTRL_BITS-1:0] cmd_q26_nxt, cmd_q26_r;

  assign cmd_q26_nxt = base_r - pi_r;

  always_ff @(posedge clk) begin
    if (ld[4]) begin
      cmd_q26_r <= cmd_q26_nxt;
    end
  end

  // Stage 5: drop the fraction with truncation toward zero (a negative value with a
  // nonzero fraction moves up by one), then saturate to the 24-bit command range.
  logic signed [Q_BITS-1:0]   cmd_int;
  logic                       round_up;
  logic signed [Q_BITS-1:0]   cmd_trunc;
  logic                       cmd_fits;
  logic signed [CMD_BITS-1:0] sat_cmd_nxt, sat_cmd_r;

  always_comb begin
    cmd_int   = cmd_q26_r[CTRL_BITS-1:FRAC_BITS];
    round_up  = cmd_q26_r[CTRL_BITS-1] && (|cmd_q26_r[FRAC_BITS-1:0]);
    cmd_trunc = cmd_int + Q_BITS'(round_up);
    cmd_fits  = (&cmd_trunc[Q_BITS-1:CMD_BITS-1]) || !(|cmd_trunc[Q_BITS-1:CMD_BITS-1]);
    if (cmd_fits) begin
      sat_cmd_nxt = cmd_trunc[CMD_BITS-1:0];
    end else begin
      sat_cmd_nxt = cmd_trunc[Q_BITS-1] ? CMD_MIN : CMD_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[5]) begin
      sat_cmd_r <= sat_cmd_nxt;
    end
  end

  // Output register: the duty is rewritten or held as the result is loaded.
  res_t res;

  tpfd_duty u_duty (
    .clk         (clk),
    .rst_n       (rst_n),
    .load        (ld[PIPE_STAGES]),
    .cmd         (sat_cmd_r),
    .duty_offset (duty_offset_r),
    .duty_upper  (duty_upper_r),
    .res         (res)
  );

  assign out_ch.drive_command = res.drive_command;
  assign out_ch.duty_value    = res.duty_value;
  assign out_ch.duty_written  = res.duty_written;

  // An empty slot in front of the output register must keep the input open, even
  // while a finished result waits for its transfer.
  `TPFD_ASSERT_HOLDS(a_bubble_keeps_input_open, !stg_v_r[PIPE_STAGES-1], in_ch.ready,
                     "input blocked although the pipeline has an empty slot")

  // The result register must hold a valid item once it is loaded from the last stage.
  `TPFD_ASSERT_NEXT(a_output_loaded_from_pipe, ld[PIPE_STAGES], out_ch.valid,
                    "result register loaded but not valid")

endmodule
